/* rtl/zle_pkg.sv */
package zle_pkg;

   // Visible line width in pixels.
   localparam int LINE_WIDTH = 448;

   localparam int PIXEL_W   = 16;
   localparam int COLOR_W   = 15;
   localparam int X_W       = 9;
   localparam int COUNT_W   = 11;
   localparam int COLUMN_W  = 5;
   localparam int START_W   = 11;
   localparam int PATTERN_W = 32;
   localparam int POS_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam int TRANSPARENT_BIT = 15;
   localparam logic [COUNT_W-1:0] DRAW_COUNT_MAX = '1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_MODE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X      = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [PATTERN_W-1:0] zoom_pattern;
      logic                 grow_mode;
      logic [START_W-1:0]   start_x;
   } zle_cfg_type;

   // One queued work entry: up to two writes of the same color.
   typedef struct packed {
      logic [X_W-1:0]     x0;
      logic [X_W-1:0]     x1;
      logic [COLOR_W-1:0] color;
      logic               v0;
      logic               v1;
   } zle_entry_type;

   // Handshake between the queue and the back end.
   typedef struct packed {
      logic          not_empty;
      zle_entry_type head;
   } zle_queue_status_type;

endpackage

/* rtl/zle_front.sv */
module zle_front
   import zle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  zle_cfg_type          cfg,
   input  logic                 accept,
   input  logic [PIXEL_W-1:0]   source_pixel,
   input  logic                 first_column,
   output logic                 push,
   output zle_entry_type        push_entry
);

   logic [COLUMN_W-1:0] source_column_ff, source_column_in;
   logic [COUNT_W-1:0]  draw_count_ff, draw_count_in;
   logic                line_finished_ff, line_finished_in;

   logic [COLUMN_W-1:0] col_v;
   logic [COUNT_W-1:0]  dc_v, dc_a, dc_b;
   logic                fin_v, active, marked, draw_one, draw_two, opaque;
   logic signed [POS_W-1:0] sx_ext, pos0, pos1;
   logic                in0, in1;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == DRAW_COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic in_line(input logic signed [POS_W-1:0] p);
      in_line = !p[POS_W-1] && (p < POS_W'(LINE_WIDTH));
   endfunction

   always_comb begin
      // A first column clears the line state before the item is handled.
      col_v  = first_column ? '0 : source_column_ff;
      dc_v   = first_column ? '0 : draw_count_ff;
      fin_v  = first_column ? 1'b0 : line_finished_ff;
      active = !fin_v;

      marked   = cfg.zoom_pattern[col_v];
      draw_one = !marked;
      draw_two = marked && cfg.grow_mode;
      opaque   = !source_pixel[TRANSPARENT_BIT];

      sx_ext = signed'({{(POS_W-START_W){cfg.start_x[START_W-1]}}, cfg.start_x});
      dc_a   = sat_inc(dc_v);
      dc_b   = sat_inc(dc_a);
      pos0   = sx_ext + signed'({{(POS_W-COUNT_W){1'b0}}, dc_v});
      pos1   = sx_ext + signed'({{(POS_W-COUNT_W){1'b0}}, dc_a});
      in0    = in_line(pos0);
      in1    = in_line(pos1);

      push_entry.x0    = pos0[X_W-1:0];
      push_entry.x1    = pos1[X_W-1:0];
      push_entry.color = source_pixel[COLOR_W-1:0];
      push_entry.v0    = active && (draw_one || draw_two) && opaque && in0;
      push_entry.v1    = active && draw_two && opaque && in1;
      push = accept && (push_entry.v0 || push_entry.v1);

      source_column_in = source_column_ff;
      draw_count_in    = draw_count_ff;
      line_finished_in = line_finished_ff;
      if (accept) begin
         source_column_in = active ? col_v + 1'b1 : col_v;
         if (!active) begin
            draw_count_in = dc_v;
         end else if (draw_two) begin
            draw_count_in = dc_b;
         end else if (draw_one) begin
            draw_count_in = dc_a;
         end else begin
            draw_count_in = dc_v;
         end
         // The line ends when the last position drawn for the column hits the width.
         line_finished_in = fin_v ||
            (active && draw_one && (pos0 == POS_W'(LINE_WIDTH))) ||
            (active && draw_two && (pos1 == POS_W'(LINE_WIDTH)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_column_ff <= '0;
         draw_count_ff    <= '0;
         line_finished_ff <= 1'b0;
      end else begin
         source_column_ff <= source_column_in;
         draw_count_ff    <= draw_count_in;
         line_finished_ff <= line_finished_in;
      end
   end

endmodule

/* rtl/zle_queue.sv */
module zle_queue
   import zle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  zle_entry_type        push_entry,
   input  logic                 pop,
   output logic                 full,
   output zle_queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   zle_entry_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      full             = (count_ff == CNT_W'(QUEUE_DEPTH));
      status.not_empty = (count_ff != '0);
      status.head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/zle_back.sv */
module zle_back
   import zle_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  zle_queue_status_type status,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [X_W-1:0]       rsp_draw_x,
   output logic [COLOR_W-1:0]   rsp_pixel_value,
   output logic                 rsp_last_of_run
);

   logic               valid_ff, valid_in;
   logic               second_ff, second_in;
   logic [X_W-1:0]     x_ff, x_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               last_ff, last_in;
   logic               load;

   always_comb begin
      load      = (!valid_ff || !rsp_stall) && status.not_empty;
      pop       = 1'b0;
      second_in = second_ff;
      x_in      = x_ff;
      color_in  = color_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         color_in = status.head.color;
         if (second_ff || !status.head.v0) begin
            x_in      = status.head.x1;
            last_in   = 1'b1;
            pop       = 1'b1;
            second_in = 1'b0;
         end else begin
            x_in    = status.head.x0;
            last_in = !status.head.v1;
            if (status.head.v1) begin
               second_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      color_ff <= color_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_draw_x      = x_ff;
   assign rsp_pixel_value = color_ff;
   assign rsp_last_of_run = last_ff;

endmodule

/* rtl/sprite_line_zoom_expander_core.sv */
// Horizontal zoom stage for one sprite line. Each request transaction carries one
// decoded source pixel (bit 15 set means transparent) and a flag that starts a new
// line. The zoom pattern bit for the source column (mod 32) decides whether the
// column is drawn once, drawn twice (grow mode) or skipped (shrink mode); every
// drawn column takes the next screen position counted from start_x. Opaque pixels
// that land inside the 448 pixel line come out as one or two response
// transactions, the last one flagged. Once a column is drawn exactly at x = 448
// the line is finished and further pixels are dropped until the next first
// column. A request transaction is taken in any cycle while the two-entry work
// queue has room, so pixels that map to one write or none stream at one per
// cycle while rsp_stall is low; a doubled column holds the single output
// register for both of its writes. A pixel's first response passes through the
// queue entry, then the output register. The user must write registers through
// the csr port only while no transaction is in flight; the core does not check it.
module sprite_line_zoom_expander_core
   import zle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_W-1:0]    req_source_pixel,
   input  logic                  req_first_column,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [X_W-1:0]        rsp_draw_x,
   output logic [COLOR_W-1:0]    rsp_pixel_value,
   output logic                  rsp_last_of_run
);

   zle_cfg_type          cfg_ff, cfg_in;
   logic                 accept;
   logic                 push;
   logic                 pop;
   logic                 full;
   zle_entry_type        push_entry;
   zle_queue_status_type status;

   // Configuration registers; writes to an unused index are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ZOOM_PATTERN: cfg_in.zoom_pattern = csr_write_data;
            CSR_GROW_MODE:    cfg_in.grow_mode    = csr_write_data[0];
            CSR_START_X:      cfg_in.start_x      = csr_write_data[START_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end updates the line state on every accepted transaction and only
   // queues work for transactions that produce at least one write.
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;

   zle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .accept       (accept),
      .source_pixel (req_source_pixel),
      .first_column (req_first_column),
      .push         (push),
      .push_entry   (push_entry)
   );

   zle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .status     (status)
   );

   zle_back u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_draw_x      (rsp_draw_x),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

/* rtl/zle_checker.sv */
module zle_checker
   import zle_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [X_W-1:0]       rsp_draw_x,
   input logic [COLOR_W-1:0]   rsp_pixel_value,
   input logic                 rsp_last_of_run
);

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_draw_x) &&
         $stable(rsp_pixel_value) && $stable(rsp_last_of_run))
      else $error("stalled response changed");

   // Nothing comes out right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Every write lands inside the line.
   a_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_draw_x < X_W'(LINE_WIDTH)))
      else $error("draw_x outside the line");

   // The first write of a doubled column is followed at once by its neighbor.
   a_double_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=>
         rsp_valid && rsp_last_of_run &&
         (rsp_draw_x == X_W'($past(rsp_draw_x) + 1'b1)) &&
         (rsp_pixel_value == $past(rsp_pixel_value)))
      else $error("doubled column pair broken");

endmodule

bind sprite_line_zoom_expander_core zle_checker u_zle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_draw_x      (rsp_draw_x),
   .rsp_pixel_value (rsp_pixel_value),
   .rsp_last_of_run (rsp_last_of_run)
);
